// File: hw/rtl/les_pkg.sv
// ----------------------------------------------------------------------------
// les_pkg
// Shared types and constants of the largest empty square finder.
// ----------------------------------------------------------------------------
package les_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_COLS      = 2'd0,
    REG_NUM_ROWS      = 2'd1,
    REG_OBSTACLE_CHAR = 2'd2
  } cfg_reg_t;

  // field widths
  localparam int unsigned DIM_W  = 11;  // num_cols, num_rows
  localparam int unsigned CHAR_W = 8;   // cell_char, obstacle_char
  localparam int unsigned SIZE_W = 11;  // square sizes in the line store
  localparam int unsigned POS_W  = 10;  // square_col, square_row

  // configuration reset values
  localparam logic [DIM_W-1:0]  NUM_COLS_RST = 11'd1;
  localparam logic [DIM_W-1:0]  NUM_ROWS_RST = 11'd1;
  localparam logic [CHAR_W-1:0] OBSTACLE_RST = 8'd0;

endpackage

// File: hw/rtl/les_ram.sv
// ----------------------------------------------------------------------------
// les_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module les_ram #(
  parameter int unsigned WIDTH = 11,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/largest_empty_square.sv
// ----------------------------------------------------------------------------
// largest_empty_square
// Streams a character grid in row-major order and reports the largest
// square of cells that holds no obstacle character.
// ----------------------------------------------------------------------------
// One cell is taken per clock cycle unless stalled, across rows and grids.
// Each cell is handled in two steps: on transfer the cell's column entry is
// read from a line store of MAX_COLS x 11 bits (one synchronous RAM), and in
// the second step the square size ending at the cell, min(up, left, up-left)
// plus one or zero for a blocked cell, is formed, written back to the same
// entry and compared with the best square so far. A write and a read of the
// same entry in one cycle are resolved by forwarding. The result (top-left
// column, top-left row, side) is loaded into the output register as the
// grid's last cell leaves the second step; ties go to the topmost, then
// leftmost top-left corner, and a fully blocked grid reports zeros. The input
// stalls only when a grid result is waiting in the output register and the
// next grid's result is already due. Dimensions of 0 act as 1 and values
// above MAX_COLS or MAX_ROWS act as the maximum. Registers are to be written
// by the user while no cell is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module largest_empty_square #(
  parameter int unsigned MAX_COLS = 1024,
  parameter int unsigned MAX_ROWS = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_we,
  input  logic [les_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [les_pkg::DIM_W-1:0]     cfg_data,
  // cell input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [les_pkg::CHAR_W-1:0]    cell_char,
  // result output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [les_pkg::POS_W-1:0]     square_col,
  output logic [les_pkg::POS_W-1:0]     square_row,
  output logic [les_pkg::SIZE_W-1:0]    square_size
);

  localparam int unsigned CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CNW = CW + 1;
  localparam int unsigned RNW = RW + 1;
  localparam int unsigned SW  = les_pkg::SIZE_W;

  // configuration registers
  logic [les_pkg::DIM_W-1:0]  num_cols;
  logic [les_pkg::DIM_W-1:0]  num_rows;
  logic [les_pkg::CHAR_W-1:0] obstacle_char;

  // grid position of the next cell
  logic [CW-1:0] col_count, col_count_next;
  logic [RW-1:0] row_count, row_count_next;

  // second step of a cell
  logic          s1_valid;
  logic [CW-1:0] s1_col;
  logic [RW-1:0] s1_row;
  logic          s1_last;
  logic          s1_fwd;
  logic [SW-1:0] s1_fwd_size;
  logic [les_pkg::CHAR_W-1:0] s1_char;

  // running sizes and best square
  logic [SW-1:0] left_size, diag_size, best_size;
  logic [CW-1:0] best_col;
  logic [RW-1:0] best_row;
  logic [SW-1:0] best_size_next;
  logic [CW-1:0] best_col_next;
  logic [RW-1:0] best_row_next;

  logic [SW-1:0] mem_rdata;
  logic          in_xfer, s1_go;

  // clamped dimensions
  logic [31:0]    cols_w, rows_w;
  logic [CNW-1:0] cols;
  logic [RNW-1:0] rows;

  always_comb begin
    cols_w = 32'(num_cols);
    if (cols_w == 32'd0) begin
      cols_w = 32'd1;
    end else if (cols_w > 32'(MAX_COLS)) begin
      cols_w = 32'(MAX_COLS);
    end
    rows_w = 32'(num_rows);
    if (rows_w == 32'd0) begin
      rows_w = 32'd1;
    end else if (rows_w > 32'(MAX_ROWS)) begin
      rows_w = 32'(MAX_ROWS);
    end
    cols = cols_w[CNW-1:0];
    rows = rows_w[RNW-1:0];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      num_cols      <= les_pkg::NUM_COLS_RST;
      num_rows      <= les_pkg::NUM_ROWS_RST;
      obstacle_char <= les_pkg::OBSTACLE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        les_pkg::REG_NUM_COLS:      num_cols      <= cfg_data;
        les_pkg::REG_NUM_ROWS:      num_rows      <= cfg_data;
        les_pkg::REG_OBSTACLE_CHAR: obstacle_char <= cfg_data[les_pkg::CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: hold only when a due result meets a full output register
  assign s1_go    = !(s1_last && out_valid && out_stall);
  assign in_stall = s1_valid && !s1_go;
  assign in_xfer  = in_valid && !in_stall;

  // position of the incoming cell, with a row or grid ended early if the
  // dimensions shrank, and the position that follows it
  logic [CW-1:0]  c0;
  logic [RW-1:0]  r0;
  logic [RNW-1:0] r_inc_pre, r_inc;
  logic [CNW-1:0] c_inc;
  logic           row_end, grid_end;

  always_comb begin
    c0        = col_count;
    r_inc_pre = {1'b0, row_count};
    if ({1'b0, col_count} >= cols) begin
      c0        = '0;
      r_inc_pre = {1'b0, row_count} + RNW'(1);
    end
    if (r_inc_pre >= rows) begin
      c0 = '0;
      r0 = '0;
    end else begin
      r0 = r_inc_pre[RW-1:0];
    end

    c_inc    = {1'b0, c0} + CNW'(1);
    r_inc    = {1'b0, r0} + RNW'(1);
    row_end  = (c_inc >= cols);
    grid_end = row_end && (r_inc >= rows);

    col_count_next = row_end ? '0 : c_inc[CW-1:0];
    if (!row_end) begin
      row_count_next = r0;
    end else if (grid_end) begin
      row_count_next = '0;
    end else begin
      row_count_next = r_inc[RW-1:0];
    end
  end

  // line store
  logic [SW-1:0] d;

  les_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_COLS)
  ) u_line (
    .clk   (clk),
    .we    (s1_valid && s1_go),
    .waddr (s1_col),
    .wdata (d),
    .re    (in_xfer),
    .raddr (c0),
    .rdata (mem_rdata)
  );

  // size of the square ending at the cell, and best square update
  logic [SW-1:0] up, up_raw, left_eff, diag_eff, m;
  logic [SW-1:0] best_size_eff;
  logic [CW-1:0] best_col_eff;
  logic [RW-1:0] best_row_eff;
  logic [31:0]   d_w, row_p1, col_p1, tr_w, tc_w;
  logic [CW-1:0] tc;
  logic [RW-1:0] tr;

  always_comb begin
    up_raw   = s1_fwd ? s1_fwd_size : mem_rdata;
    up       = (s1_row != '0) ? up_raw : '0;
    left_eff = (s1_col != '0) ? left_size : '0;
    diag_eff = (s1_col != '0) ? diag_size : '0;

    m = up;
    if (left_eff < m) begin
      m = left_eff;
    end
    if (diag_eff < m) begin
      m = diag_eff;
    end
    d = (s1_char == obstacle_char) ? '0 : m + SW'(1);

    // a new grid starts from an empty best
    if (s1_row == '0 && s1_col == '0) begin
      best_size_eff = '0;
      best_col_eff  = '0;
      best_row_eff  = '0;
    end else begin
      best_size_eff = best_size;
      best_col_eff  = best_col;
      best_row_eff  = best_row;
    end

    d_w    = 32'(d);
    row_p1 = 32'(s1_row) + 32'd1;
    col_p1 = 32'(s1_col) + 32'd1;
    tr_w   = row_p1 - d_w;
    tc_w   = col_p1 - d_w;
    tr     = tr_w[RW-1:0];
    tc     = tc_w[CW-1:0];

    best_size_next = best_size_eff;
    best_col_next  = best_col_eff;
    best_row_next  = best_row_eff;
    if (d != '0 && d_w <= row_p1 && d_w <= col_p1) begin
      if (d > best_size_eff) begin
        best_size_next = d;
        best_row_next  = tr;
        best_col_next  = tc;
      end else if (d == best_size_eff &&
                   (tr < best_row_eff || (tr == best_row_eff && tc < best_col_eff))) begin
        best_row_next = tr;
        best_col_next = tc;
      end
    end
  end

  // second step registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      col_count <= '0;
      row_count <= '0;
    end else begin
      if (in_xfer) begin
        s1_valid  <= 1'b1;
        col_count <= col_count_next;
        row_count <= row_count_next;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // cell payload into the second step, with forwarding of a same-entry write
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_col      <= c0;
      s1_row      <= r0;
      s1_last     <= grid_end;
      s1_char     <= cell_char;
      s1_fwd      <= s1_valid && (s1_col == c0);
      s1_fwd_size <= d;
    end
  end

  // running sizes and best square
  always_ff @(posedge clk) begin
    if (rst) begin
      left_size <= '0;
      diag_size <= '0;
      best_size <= '0;
      best_col  <= '0;
      best_row  <= '0;
    end else if (s1_valid && s1_go) begin
      left_size <= d;
      diag_size <= up;
      best_size <= best_size_next;
      best_col  <= best_col_next;
      best_row  <= best_row_next;
    end
  end

  // result output register
  logic [31:0] res_col_w, res_row_w;
  assign res_col_w = 32'(best_col_next);
  assign res_row_w = 32'(best_row_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_go && s1_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_go && s1_last) begin
      square_col  <= res_col_w[les_pkg::POS_W-1:0];
      square_row  <= res_row_w[les_pkg::POS_W-1:0];
      square_size <= best_size_next;
    end
  end

endmodule

// File: sim/largest_empty_square_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// largest_empty_square_test
// Self-checking bench for the largest empty square finder. Grids of cells
// stream in with random gaps and output back-pressure. A behavioral line-store
// predictor computes the expected square of each grid, and each output
// transfer is checked against it in order.
// ----------------------------------------------------------------------------
module largest_empty_square_test;

  typedef logic [les_pkg::CHAR_W-1:0] char_t;
  typedef logic [les_pkg::DIM_W-1:0]  dim_t;
  typedef logic [les_pkg::POS_W-1:0]  pos_t;
  typedef logic [les_pkg::SIZE_W-1:0] sq_size_t;

  typedef struct packed {
    pos_t     col;
    pos_t     row;
    sq_size_t size;
  } square_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [les_pkg::CFG_IDX_W-1:0] cfg_index = les_pkg::REG_NUM_COLS;
  dim_t                          cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  char_t                         cell_char = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  pos_t                          square_col;
  pos_t                          square_row;
  sq_size_t                      square_size;

  // idle rates in percent and the long receiver hold-off request
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int mismatch_count = 0;

  square_t expected_squares[$];

  // predictor copy of the registers and the grid state
  dim_t     cfg_cols = les_pkg::NUM_COLS_RST;
  dim_t     cfg_rows = les_pkg::NUM_ROWS_RST;
  char_t    cfg_obs = les_pkg::OBSTACLE_RST;
  sq_size_t line_sizes [1024];
  sq_size_t left_sz = '0;
  sq_size_t diag_sz = '0;
  sq_size_t best_sz = '0;
  pos_t     best_c = '0;
  pos_t     best_r = '0;
  int col_cnt = 0;
  int row_cnt = 0;

  largest_empty_square dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cell_char   (cell_char),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .square_col  (square_col),
    .square_row  (square_row),
    .square_size (square_size)
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #16_000_000;
    $display("status: fail");
    $finish;
  end

  // effective dimension: zero acts as one, oversized acts as the max
  function automatic int eff_dim(input dim_t v);
    if (v == 0) return 1;
    if (v > 1024) return 1024;
    return int'(v);
  endfunction

  function automatic void start_row();
    col_cnt = 0;
    left_sz = '0;
    diag_sz = '0;
  endfunction

  function automatic void start_grid();
    start_row();
    row_cnt = 0;
    best_sz = '0;
    best_c = '0;
    best_r = '0;
  endfunction

  // one cell through the square-size recurrence; returns 1 when a grid ends
  function automatic bit square_of_cell(input char_t ch, output square_t sq);
    int cols, rows, up, sz, m, top_r, top_c;
    cols = eff_dim(cfg_cols);
    rows = eff_dim(cfg_rows);
    sq = '0;
    // width or height may have shrunk while the grid was open
    if (col_cnt >= cols) begin
      start_row();
      row_cnt++;
    end
    if (row_cnt >= rows) start_grid();
    up = (row_cnt > 0) ? int'(line_sizes[col_cnt]) : 0;
    if (ch == cfg_obs) begin
      sz = 0;
    end else begin
      m = up;
      if (int'(left_sz) < m) m = int'(left_sz);
      if (int'(diag_sz) < m) m = int'(diag_sz);
      sz = (m + 1) & 'h7FF;
    end
    // keep the topmost, then leftmost, top-left corner on ties
    if (sz > 0 && sz <= row_cnt + 1 && sz <= col_cnt + 1) begin
      top_r = row_cnt + 1 - sz;
      top_c = col_cnt + 1 - sz;
      if (sz > int'(best_sz)) begin
        best_sz = sq_size_t'(sz);
        best_r = pos_t'(top_r);
        best_c = pos_t'(top_c);
      end else if (sz == int'(best_sz) &&
                   (top_r < int'(best_r) || (top_r == int'(best_r) && top_c < int'(best_c)))) begin
        best_r = pos_t'(top_r);
        best_c = pos_t'(top_c);
      end
    end
    line_sizes[col_cnt] = sq_size_t'(sz);
    diag_sz = sq_size_t'(up);
    left_sz = sq_size_t'(sz);
    col_cnt++;
    if (col_cnt >= cols) begin
      start_row();
      row_cnt++;
      if (row_cnt >= rows) begin
        sq.col = best_c;
        sq.row = best_r;
        sq.size = best_sz;
        start_grid();
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // offer one cell, with random sender gaps, and predict on transfer
  task automatic send_cell(input char_t ch);
    square_t sq;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cell_char <= ch;
    do @(posedge clk); while (in_stall);
    if (square_of_cell(ch, sq)) expected_squares.push_back(sq);
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_cell(s[i]);
  endtask

  // stop offering, wait for every expected square, then let the pipe empty
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_squares.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write all three registers while nothing is in flight
  task automatic set_config(input dim_t cols, input dim_t rows, input char_t obs);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= les_pkg::REG_NUM_COLS;
    cfg_data <= cols;
    @(posedge clk);
    cfg_index <= les_pkg::REG_NUM_ROWS;
    cfg_data <= rows;
    @(posedge clk);
    cfg_index <= les_pkg::REG_OBSTACLE_CHAR;
    cfg_data <= {{(les_pkg::DIM_W-les_pkg::CHAR_W){1'b0}}, obs};
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_cols = cols;
    cfg_rows = rows;
    cfg_obs = obs;
  endtask

  // receiver: random stalls, or a long counted hold-off on request
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin : check_squares
    square_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_squares.size() == 0) begin
        report_mismatch($sformatf("unexpected square col %0d row %0d size %0d",
                                  square_col, square_row, square_size));
      end else begin
        want = expected_squares.pop_front();
        if (square_col !== want.col)
          report_mismatch($sformatf("square_col got %0d want %0d", square_col, want.col));
        if (square_row !== want.row)
          report_mismatch($sformatf("square_row got %0d want %0d", square_row, want.row));
        if (square_size !== want.size)
          report_mismatch($sformatf("square_size got %0d want %0d", square_size, want.size));
      end
    end
  end

  // reset register values, one-cell grids
  task automatic test_reset_defaults();
    send_cell(8'h00);
    send_cell(8'hFF);
    send_cell(8'h01);
  endtask

  // zero width or zero height acts as one
  task automatic test_dim_limits();
    // zero height, a single row of six cells
    set_config(11'd6, 11'd0, "o");
    send_text("..o...");
    // zero width, a single column of three cells
    set_config(11'd0, 11'd3, 8'hFF);
    send_cell(8'hFF);
    send_cell(8'h00);
    send_cell(8'h00);
  endtask

  task automatic test_all_blocked();
    set_config(11'd3, 11'd3, "#");
    send_text("#########");
    set_config(11'd2, 11'd2, 8'hFF);
    send_text("\xff\xff\xff\xff");
  endtask

  // equal squares on one row and a larger one further down
  task automatic test_ties();
    set_config(11'd5, 11'd4, "#");
    send_text("..#....#..######..#..");
    set_config(11'd5, 11'd6, "#");
    send_text("..#....#..######...#....#....#...");
  endtask

  // width and height lowered while a grid is open
  task automatic test_shrink_mid_grid();
    set_config(11'd4, 11'd4, "#");
    send_text("......");
    set_config(11'd2, 11'd4, "#");
    send_text("....");
    set_config(11'd3, 11'd3, "#");
    send_text(".......");
    set_config(11'd3, 11'd2, "#");
    send_text("..#...");
  endtask

  // width raised while a grid is open; old line store entries stay in use
  task automatic test_widen_mid_grid();
    set_config(11'd2, 11'd3, "#");
    send_text("...");
    set_config(11'd6, 11'd3, "#");
    send_text("...........");
  endtask

  // receiver holds off long enough that the input has to stall
  task automatic test_back_pressure();
    int i;
    set_config(11'd1, 11'd1, "#");
    hold_req = 300;
    for (i = 0; i < 24; i++)
      send_cell(($urandom_range(3) == 0) ? char_t'("#") : char_t'($urandom_range(255)));
    wait_drained();
  endtask

  function automatic dim_t pick_dim();
    int r;
    r = $urandom_range(99);
    if (r < 4) return '0;
    if (r < 85) return dim_t'($urandom_range(6, 1));
    return dim_t'($urandom_range(24, 7));
  endfunction

  // whole grids with random size, obstacle and density
  task automatic test_random_grids(input int n_cells);
    int sent, cells, density, i;
    char_t obs;
    sent = 0;
    while (sent < n_cells) begin
      if ($urandom_range(1) == 0) begin
        case ($urandom_range(3))
          0: obs = 8'h00;
          1: obs = 8'hFF;
          default: obs = char_t'($urandom_range(255));
        endcase
        set_config(pick_dim(), pick_dim(), obs);
      end
      case ($urandom_range(9))
        0: density = 0;
        1: density = 100;
        default: density = $urandom_range(40);
      endcase
      cells = eff_dim(cfg_cols) * eff_dim(cfg_rows);
      for (i = 0; i < cells; i++)
        send_cell(($urandom_range(99) < density) ? cfg_obs : char_t'($urandom_range(255)));
      sent += cells;
      // sender pause until the grid result is out
      if ($urandom_range(9) == 0) wait_drained();
    end
  endtask

  // test sequence
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_dim_limits();
    test_all_blocked();
    test_ties();
    test_shrink_mid_grid();
    test_widen_mid_grid();
    test_back_pressure();

    send_idle_pct = 8;
    recv_idle_pct = 87;
    test_random_grids(170);
    send_idle_pct = 87;
    recv_idle_pct = 8;
    test_random_grids(170);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_grids(170);

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_squares.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/les_pkg.sv
hw/rtl/les_ram.sv
hw/rtl/largest_empty_square.sv
sim/largest_empty_square_test.sv
